// File: rtl/pne_pkg.sv
// Package for the packed nibble pixel engine.
// Holds screen geometry, store sizing, request and raster op codes, shared types.
// No dependencies.
package pne_pkg;

  localparam int SCREEN_WIDTH  = 640;
  localparam int SCREEN_HEIGHT = 480;

  localparam int ROW_BYTES   = SCREEN_WIDTH / 2;
  localparam int STORE_BYTES = (SCREEN_HEIGHT - 1) * ROW_BYTES + ((SCREEN_WIDTH - 1) / 2) + 1;
  localparam int ADDR_W      = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
  localparam int Y_W         = (SCREEN_HEIGHT > 1) ? $clog2(SCREEN_HEIGHT) : 1;

  localparam logic [ADDR_W-1:0] ROW_BYTES_A = ADDR_W'(ROW_BYTES);
  localparam logic [ADDR_W-1:0] LAST_ADDR   = ADDR_W'(STORE_BYTES - 1);
  localparam logic [15:0]       WIDTH_16    = 16'(SCREEN_WIDTH);
  localparam logic [15:0]       HEIGHT_16   = 16'(SCREEN_HEIGHT);

  localparam logic [3:0] NIBBLE_MASK      = 4'hF;
  localparam logic [7:0] HIGH_MASK        = 8'hF0;
  localparam logic [7:0] OFF_SCREEN_VALUE = 8'hFF;

  typedef enum logic [1:0] {
    REQ_READ   = 2'd0,
    REQ_PLOT   = 2'd1,
    REQ_MASKED = 2'd2
  } req_t;

  typedef enum logic [1:0] {
    ROP_COPY = 2'd0,
    ROP_OR   = 2'd1,
    ROP_AND  = 2'd2,
    ROP_XOR  = 2'd3
  } rop_t;

  typedef enum logic {
    ST_CLEAR = 1'b0,
    ST_RUN   = 1'b1
  } store_state_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } wr_req_t;

endpackage

// File: rtl/packed_nibble_pixel_engine.sv
// Top level of the packed nibble pixel engine: request decode, read-modify-write
// of packed 4-bit pixels with same-byte forwarding, result register.
// Depends on pne_pkg and pne_frame_store.
//
//   channel  | handshake        | payload
//   ---------+------------------+------------------------------------------------
//   request  | start / busy     | req_type, pixel_x, pixel_y, colour, raster_op
//   result   | done (strobe)    | read_value, clipped
//
// One request is taken per cycle whenever busy is low; its result strobes on done
// after the valid1 and done registers. The frame store RAM sets this: the read is
// issued at the transfer, the byte is modified and written back in the next
// cycle, and a write to the byte just read is forwarded.
// After reset busy stays high while all STORE_BYTES bytes (153600 at 640 x 480)
// of the store are swept to zero. The receiver cannot stall results.
module packed_nibble_pixel_engine
  import pne_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  req_type,
  input  logic [15:0] pixel_x,
  input  logic [15:0] pixel_y,
  input  logic [3:0]  colour,
  input  logic [1:0]  raster_op,
  output logic        done,
  output logic [7:0]  read_value,
  output logic        clipped
);

  logic              accept;
  logic              off0;
  logic [ADDR_W-1:0] addr0;

  logic              valid1;
  logic [1:0]        req1;
  logic              off1;
  logic              odd1;
  logic [3:0]        colour1;
  logic [1:0]        rop1;
  logic [ADDR_W-1:0] addr1;

  logic [7:0]        rd_data;
  logic              last_valid;
  logic [ADDR_W-1:0] last_addr;
  logic [7:0]        last_data;

  logic [7:0]        old_byte;
  logic [3:0]        old_nib;
  logic [3:0]        ink;
  logic [7:0]        new_byte;
  logic [7:0]        value_next;
  logic              clip_next;
  wr_req_t           wr;
  logic              clearing;

  assign busy   = clearing;
  assign accept = start && !busy;
  assign off0   = (pixel_x >= WIDTH_16) || (pixel_y >= HEIGHT_16);
  assign addr0  = ADDR_W'(pixel_y[Y_W-1:0]) * ROW_BYTES_A + ADDR_W'(pixel_x[15:1]);

  pne_frame_store u_store (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (accept),
    .rd_addr  (addr0),
    .rd_data  (rd_data),
    .wr       (wr),
    .clearing (clearing)
  );

  always_ff @(posedge clk) begin
    if (rst) valid1 <= 1'b0;
    else     valid1 <= accept;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req1    <= req_type;
      off1    <= off0;
      odd1    <= pixel_x[0];
      colour1 <= colour;
      rop1    <= raster_op;
      addr1   <= addr0;
    end
  end

  always_comb begin
    old_byte = (last_valid && (last_addr == addr1)) ? last_data : rd_data;
    old_nib  = odd1 ? old_byte[3:0] : old_byte[7:4];
    ink      = colour1;
    if (req1 == REQ_PLOT) begin
      case (rop1)
        ROP_COPY: ink = colour1;
        ROP_OR:   ink = colour1 | old_nib;
        ROP_AND:  ink = colour1 & old_nib;
        ROP_XOR:  ink = colour1 ^ old_nib;
        default:  ink = colour1;
      endcase
    end
    new_byte = odd1 ? ((old_byte & HIGH_MASK) | {4'h0, ink & NIBBLE_MASK})
                    : ((old_byte & {4'h0, NIBBLE_MASK}) | {ink & NIBBLE_MASK, 4'h0});

    wr.en      = 1'b0;
    wr.addr    = addr1;
    wr.data    = new_byte;
    value_next = 8'h00;
    clip_next  = 1'b0;
    case (req1)
      REQ_READ: begin
        clip_next  = off1;
        value_next = off1 ? OFF_SCREEN_VALUE : {4'h0, old_nib};
      end
      REQ_PLOT: begin
        clip_next = off1;
        wr.en     = valid1 && !off1;
      end
      REQ_MASKED: begin
        clip_next = off1;
        wr.en     = valid1 && !off1 && (colour1 != 4'h0);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_valid <= 1'b0;
      done       <= 1'b0;
    end else begin
      last_valid <= wr.en;
      done       <= valid1;
    end
  end

  always_ff @(posedge clk) begin
    last_addr  <= wr.addr;
    last_data  <= wr.data;
    read_value <= value_next;
    clipped    <= clip_next;
  end

endmodule

// File: rtl/pne_frame_store.sv
// Frame store of the packed nibble pixel engine: one byte-wide synchronous RAM,
// one read and one write port, with a clearing sweep after reset.
// Depends on pne_pkg.
module pne_frame_store
  import pne_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [7:0]        rd_data,
  input  wr_req_t           wr,
  output logic              clearing
);

  logic [7:0] mem [STORE_BYTES];

  store_state_t      state;
  store_state_t      state_next;
  logic [ADDR_W-1:0] clr_addr;
  logic [ADDR_W-1:0] clr_addr_next;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [7:0]        mem_wdata;

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: if (clr_addr == LAST_ADDR) state_next = ST_RUN;
      ST_RUN:   state_next = ST_RUN;
      default:  state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    clearing      = 1'b0;
    clr_addr_next = clr_addr;
    mem_we        = wr.en;
    mem_waddr     = wr.addr;
    mem_wdata     = wr.data;
    case (state)
      ST_CLEAR: begin
        clearing      = 1'b1;
        clr_addr_next = clr_addr + 1'b1;
        mem_we        = 1'b1;
        mem_waddr     = clr_addr;
        mem_wdata     = 8'h00;
      end
      ST_RUN: ;
      default: clearing = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
    end else begin
      state    <= state_next;
      clr_addr <= clr_addr_next;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
  end

  always_ff @(posedge clk) begin
    if (rd_en) rd_data <= mem[rd_addr];
  end

endmodule
